### src/itt_pkg.sv
// itt_pkg: shared types and constants for the interval/timeout timer table
// no dependencies
`timescale 1ns / 1ps
package itt_pkg;

  localparam int unsigned MaxTasks   = 16;
  localparam int unsigned IdBits     = 16;
  localparam int unsigned ClearDepth = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned FifoDepth  = 2;

  typedef enum logic [2:0] {
    OP_ADD_INTERVAL = 3'd0,
    OP_ADD_TIMEOUT  = 3'd1,
    OP_CLEAR_ID     = 3'd2,
    OP_TICK         = 3'd3,
    OP_RESTART_ALL  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_ASSIGNED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_FIRED    = 2'd2
  } kind_e;

  // command handed from front to back
  typedef struct packed {
    op_e         op;
    logic [31:0] period;
    logic [31:0] now;
    logic [15:0] target;
    logic [7:0]  tag;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CLEAR_SHIFT,
    ST_FIRE,
    ST_REMOVE,
    ST_OUT
  } state_e;

endpackage

### src/interval_timeout_timer_table.sv
// interval_timeout_timer_table: top level of the timer table
// depends on itt_pkg, itt_front, itt_back
//
// Channels: input items (operation, period, now, target id, owner tag) on
// in_valid_i/in_ready_o; results (kind, timer id, tag, last_of_run) on
// out_valid_o/out_ready_i. A transfer happens when valid and ready are high.
// An add gives one result once the sequencer is idle; the result passes
// through the command queue and the output register. A clear or a restart
// gives none. A tick walks the table one entry per cycle while the output
// can take results: one pass per queued clear, a check of the clear queue,
// a fire pass, a removal pass, and a final step that hands out the last
// fire. The back sequencer performs this entry walk.
// A two-entry command queue sits between the front and the sequencer.
// Reset empties the table, the clear queue and the command queue; ids start
// at 1. A stalled receiver holds the output register and one skid entry; the
// sequencer then pauses until the result can be taken.
`timescale 1ns / 1ps
module interval_timeout_timer_table #(
  parameter int unsigned MAX_TASKS = itt_pkg::MaxTasks,
  parameter int unsigned ID_BITS   = itt_pkg::IdBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] period_ms_i,
  input  logic [31:0] now_ms_i,
  input  logic [15:0] target_id_i,
  input  logic [7:0]  owner_tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [15:0] timer_id_o,
  output logic [7:0]  tag_out_o,
  output logic        last_of_run_o
);
  logic          cmd_valid, cmd_ready;
  itt_pkg::cmd_t cmd;

  itt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .period_ms_i,
    .now_ms_i, .target_id_i, .owner_tag_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  itt_back #(.MAX_TASKS(MAX_TASKS), .ID_BITS(ID_BITS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o, .out_ready_i, .kind_o,
    .timer_id_o, .tag_out_o, .last_of_run_o
  );

endmodule

### src/itt_front.sv
// itt_front: input stage; drops unknown operations and queues commands
// depends on itt_pkg
`timescale 1ns / 1ps
module itt_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           operation_i,
  input  logic [31:0]          period_ms_i,
  input  logic [31:0]          now_ms_i,
  input  logic [15:0]          target_id_i,
  input  logic [7:0]           owner_tag_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output itt_pkg::cmd_t        cmd_o
);
  localparam int unsigned AW = $clog2(itt_pkg::FifoDepth);

  itt_pkg::cmd_t      mem_q [itt_pkg::FifoDepth];
  logic [AW-1:0]      wr_q, rd_q;
  logic [AW:0]        cnt_q;
  logic               known, push, pop;

  assign known      = (operation_i <= itt_pkg::OP_RESTART_ALL);
  assign in_ready_o = (cnt_q != (AW+1)'(itt_pkg::FifoDepth));
  assign push       = in_valid_i && in_ready_o && known;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop        = cmd_valid_o && cmd_ready_i;
  assign cmd_o      = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{op: itt_pkg::op_e'(operation_i), period: period_ms_i,
                       now: now_ms_i, target: target_id_i, tag: owner_tag_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(itt_pkg::FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(itt_pkg::FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(itt_pkg::FifoDepth)) else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !known) |=> (cnt_q == $past(cnt_q) - (AW+1)'($past(pop))))
    else $error("unknown op queued");

endmodule

### src/itt_back.sv
// itt_back: timer table storage and sequencer walking entries one per cycle unless stalled
// depends on itt_pkg
`timescale 1ns / 1ps
module itt_back #(
  parameter int unsigned MAX_TASKS = itt_pkg::MaxTasks,
  parameter int unsigned ID_BITS   = itt_pkg::IdBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  itt_pkg::cmd_t  cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     kind_o,
  output logic [15:0]    timer_id_o,
  output logic [7:0]     tag_out_o,
  output logic           last_of_run_o
);
  localparam int unsigned EW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(itt_pkg::ClearDepth);
  localparam int unsigned RW = $clog2(itt_pkg::MaxResults + 1);

  logic [ID_BITS-1:0] id_q   [MAX_TASKS];
  logic [31:0]        per_q  [MAX_TASKS];
  logic [31:0]        st_q   [MAX_TASKS];
  logic               tmo_q  [MAX_TASKS];
  logic [7:0]         tag_q  [MAX_TASKS];
  logic [MAX_TASKS-1:0] fired_q;
  logic [EW:0]        used_q;
  logic [ID_BITS-1:0] next_id_q;
  logic [15:0]        clr_q [itt_pkg::ClearDepth];
  logic [CW:0]        clr_cnt_q;
  logic [CW:0]        ci_q;
  logic [EW:0]        ei_q;
  logic [RW-1:0]      k_q;
  itt_pkg::cmd_t      cmd_q;
  itt_pkg::state_e    state_q, state_d;

  // result register plus one skid entry
  logic        ov_q, last_q;
  logic [1:0]  okind_q;
  logic [15:0] oid_q;
  logic [7:0]  otag_q;
  logic        pend_q;
  logic [1:0]  pkind_q;
  logic [15:0] pid_q;
  logic [7:0]  ptag_q;
  logic        plast_q;

  logic        emit;
  logic [1:0]  ekind;
  logic [15:0] eid;
  logic [7:0]  etag;
  logic        room;
  logic [EW-1:0] ei;
  logic          ready_hit;
  logic [ID_BITS-1:0] nid_inc;

  assign ei = ei_q[EW-1:0];
  assign room = !pend_q;
  assign cmd_ready_o = (state_q == itt_pkg::ST_IDLE) && room;
  assign ready_hit = ((cmd_q.now - st_q[ei]) >= per_q[ei]);
  assign nid_inc = next_id_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= itt_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    emit = 1'b0; ekind = itt_pkg::KIND_FIRED; eid = '0; etag = '0;
    unique case (state_q)
      itt_pkg::ST_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          unique case (cmd_i.op)
            itt_pkg::OP_ADD_INTERVAL, itt_pkg::OP_ADD_TIMEOUT: begin
              emit = 1'b1;
              if (used_q == (EW+1)'(MAX_TASKS)) begin
                ekind = itt_pkg::KIND_FULL;
              end else begin
                ekind = itt_pkg::KIND_ASSIGNED;
                eid = 16'(next_id_q);
                etag = cmd_i.tag;
              end
            end
            itt_pkg::OP_TICK: state_d = itt_pkg::ST_CLEAR;
            default: ;
          endcase
        end
      end
      itt_pkg::ST_CLEAR: begin
        if (ci_q == clr_cnt_q) state_d = itt_pkg::ST_FIRE;
        else if (ei_q == used_q) state_d = itt_pkg::ST_CLEAR;
        else if (32'(id_q[ei]) == 32'(clr_q[ci_q[CW-1:0]]))
          state_d = itt_pkg::ST_CLEAR_SHIFT;
      end
      itt_pkg::ST_CLEAR_SHIFT: begin
        if (ei_q + 1'b1 >= used_q) state_d = itt_pkg::ST_CLEAR;
      end
      itt_pkg::ST_FIRE: begin
        if (ei_q == used_q) state_d = itt_pkg::ST_REMOVE;
        else if (room && k_q != RW'(itt_pkg::MaxResults) && ready_hit) begin
          emit = 1'b1; ekind = itt_pkg::KIND_FIRED;
          eid = 16'(id_q[ei]); etag = tag_q[ei];
        end
      end
      itt_pkg::ST_REMOVE: begin
        if (ei_q == '0) state_d = itt_pkg::ST_OUT;
      end
      itt_pkg::ST_OUT: begin
        if (room) state_d = itt_pkg::ST_IDLE;
      end
      default: state_d = itt_pkg::ST_IDLE;
    endcase
  end

  // sequencer counters; in the removal pass the entry being checked is at ei_q - 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      next_id_q <= ID_BITS'(1);
      clr_cnt_q <= '0;
      ci_q      <= '0;
      ei_q      <= '0;
      k_q       <= '0;
      fired_q   <= '0;
    end else begin
      unique case (state_q)
        itt_pkg::ST_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            unique case (cmd_i.op)
              itt_pkg::OP_ADD_INTERVAL, itt_pkg::OP_ADD_TIMEOUT: begin
                if (used_q != (EW+1)'(MAX_TASKS)) begin
                  used_q <= used_q + 1'b1;
                  next_id_q <= (nid_inc == '0) ? ID_BITS'(1) : nid_inc;
                end
              end
              itt_pkg::OP_CLEAR_ID:
                if (clr_cnt_q != (CW+1)'(itt_pkg::ClearDepth))
                  clr_cnt_q <= clr_cnt_q + 1'b1;
              itt_pkg::OP_TICK: begin
                ci_q <= '0; ei_q <= '0; k_q <= '0; fired_q <= '0;
              end
              default: ;
            endcase
          end
        end
        itt_pkg::ST_CLEAR: begin
          if (ci_q == clr_cnt_q) begin
            clr_cnt_q <= '0; ei_q <= '0;
          end else if (state_d == itt_pkg::ST_CLEAR_SHIFT) begin
            ;
          end else if (ei_q == used_q) begin
            ci_q <= ci_q + 1'b1; ei_q <= '0;
          end else begin
            ei_q <= ei_q + 1'b1;
          end
        end
        itt_pkg::ST_CLEAR_SHIFT: begin
          if (ei_q + 1'b1 >= used_q) begin
            used_q <= used_q - 1'b1; ci_q <= ci_q + 1'b1; ei_q <= '0;
          end else begin
            ei_q <= ei_q + 1'b1;
          end
        end
        itt_pkg::ST_FIRE: begin
          if (ei_q == used_q) begin
            ei_q <= used_q;
          end else if (room) begin
            if (emit) begin
              k_q <= k_q + 1'b1;
              fired_q[ei] <= 1'b1;
            end
            ei_q <= ei_q + 1'b1;
          end
        end
        itt_pkg::ST_REMOVE: begin
          // walk from the top down, removing fired timeouts one per cycle
          if (ei_q != '0) begin
            if (fired_q[EW'(ei_q - 1'b1)] && tmo_q[EW'(ei_q - 1'b1)]) begin
              fired_q[EW'(ei_q - 1'b1)] <= 1'b0;
              used_q <= used_q - 1'b1;
            end
            ei_q <= ei_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (state_q == itt_pkg::ST_IDLE && cmd_valid_i && cmd_ready_o) begin
      cmd_q <= cmd_i;
      if ((cmd_i.op == itt_pkg::OP_ADD_INTERVAL || cmd_i.op == itt_pkg::OP_ADD_TIMEOUT)
          && used_q != (EW+1)'(MAX_TASKS)) begin
        id_q[EW'(used_q)]  <= next_id_q;
        per_q[EW'(used_q)] <= cmd_i.period;
        st_q[EW'(used_q)]  <= cmd_i.now;
        tmo_q[EW'(used_q)] <= (cmd_i.op == itt_pkg::OP_ADD_TIMEOUT);
        tag_q[EW'(used_q)] <= cmd_i.tag;
      end
      if (cmd_i.op == itt_pkg::OP_CLEAR_ID && clr_cnt_q != (CW+1)'(itt_pkg::ClearDepth))
        clr_q[clr_cnt_q[CW-1:0]] <= cmd_i.target;
      if (cmd_i.op == itt_pkg::OP_RESTART_ALL)
        for (int i = 0; i < MAX_TASKS; i++) st_q[i] <= cmd_i.now;
    end
    if (state_q == itt_pkg::ST_FIRE && emit) st_q[ei] <= cmd_q.now;
    // compaction: move entries above the removed slot down by one
    if ((state_q == itt_pkg::ST_CLEAR_SHIFT && ei_q + 1'b1 < used_q)) begin
      id_q[ei]  <= id_q[EW'(ei_q + 1'b1)];
      per_q[ei] <= per_q[EW'(ei_q + 1'b1)];
      st_q[ei]  <= st_q[EW'(ei_q + 1'b1)];
      tmo_q[ei] <= tmo_q[EW'(ei_q + 1'b1)];
      tag_q[ei] <= tag_q[EW'(ei_q + 1'b1)];
    end
    if (state_q == itt_pkg::ST_REMOVE && ei_q != '0 &&
        fired_q[EW'(ei_q - 1'b1)] && tmo_q[EW'(ei_q - 1'b1)]) begin
      for (int i = 0; i < MAX_TASKS - 1; i++) begin
        if (EW'(i) >= EW'(ei_q - 1'b1)) begin
          id_q[i]  <= id_q[i+1];
          per_q[i] <= per_q[i+1];
          st_q[i]  <= st_q[i+1];
          tmo_q[i] <= tmo_q[i+1];
          tag_q[i] <= tag_q[i+1];
        end
      end
    end
  end

  // output register with one skid entry; last flag is set on every add result and on
  // the final fire, by holding each fire until the next one and marking it when the run ends
  logic        hv_q;
  logic [15:0] hid_q;
  logic [7:0]  htag_q;
  logic        flush, push_now, push_last;
  logic [1:0]  pk;
  logic [15:0] pi;
  logic [7:0]  pt;

  assign flush = (state_q == itt_pkg::ST_OUT) && room && hv_q;
  always_comb begin
    push_now = 1'b0; push_last = 1'b0; pk = itt_pkg::KIND_FIRED; pi = hid_q; pt = htag_q;
    if (state_q == itt_pkg::ST_IDLE && emit) begin
      push_now = 1'b1; push_last = 1'b1; pk = ekind; pi = eid; pt = etag;
    end else if (state_q == itt_pkg::ST_FIRE && emit && hv_q) begin
      push_now = 1'b1;
    end else if (flush) begin
      push_now = 1'b1; push_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= 1'b0; ov_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      if (state_q == itt_pkg::ST_FIRE && emit) hv_q <= 1'b1;
      else if (flush) hv_q <= 1'b0;
      if (ov_q && out_ready_i) begin
        if (pend_q) begin
          pend_q <= push_now;
        end else begin
          ov_q <= push_now;
        end
      end else if (push_now) begin
        if (ov_q) pend_q <= 1'b1;
        else      ov_q   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == itt_pkg::ST_FIRE && emit) begin
      hid_q <= eid; htag_q <= etag;
    end
    if (ov_q && out_ready_i) begin
      if (pend_q) begin
        okind_q <= pkind_q; oid_q <= pid_q; otag_q <= ptag_q; last_q <= plast_q;
        if (push_now) begin
          pkind_q <= pk; pid_q <= pi; ptag_q <= pt; plast_q <= push_last;
        end
      end else if (push_now) begin
        okind_q <= pk; oid_q <= pi; otag_q <= pt; last_q <= push_last;
      end
    end else if (push_now) begin
      if (ov_q) begin
        pkind_q <= pk; pid_q <= pi; ptag_q <= pt; plast_q <= push_last;
      end else begin
        okind_q <= pk; oid_q <= pi; otag_q <= pt; last_q <= push_last;
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign kind_o        = okind_q;
  assign timer_id_o    = oid_q;
  assign tag_out_o     = otag_q;
  assign last_of_run_o = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= (EW+1)'(MAX_TASKS)) else $error("table count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != '0) else $error("zero id issued");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ov_q) else $error("skid full with empty output");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= RW'(itt_pkg::MaxResults)) else $error("too many fires");

endmodule
